FILE: src/vrp_pkg.sv
// Shared types and constants for the vMF roughness prefilter.
`default_nettype none
package vrp_pkg;

	localparam int MAX_WINDOW_LOG2 = 6;
	localparam int SAMPLE_BITS = 16;
	localparam int WLOG_W = 4;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] THRESH_Q32 = 32'd171798692;
	localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
	localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

	typedef struct packed {
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [15:0] normal_z;
		logic [15:0] base_roughness;
	} sample_t;

	typedef struct packed {
		logic [15:0] roughness_out;
		logic        fully_aligned;
	} result_t;

	typedef struct packed {
		sample_t           smp;
		logic              last;
		logic [WLOG_W-1:0] wlog;
	} qitem_t;

	typedef enum logic [3:0] {
		BS_IDLE,
		BS_SQ,
		BS_NSQRT,
		BS_DSET,
		BS_DIV,
		BS_SUMSQ,
		BS_RSET,
		BS_RSQRT,
		BS_R2,
		BS_DEN,
		BS_THR,
		BS_WDIV,
		BS_RMS,
		BS_OSQRT,
		BS_EMIT
	} back_state_t;

endpackage
`default_nettype wire

FILE: src/vmf_roughness_prefilter.sv
// Top level of the vMF roughness prefilter.
// Usage:
//   Samples arrive on sample / sample_valid / sample_stall; a sample is taken at a clock
//   edge with sample_valid high and sample_stall low. Each window of
//   4^min(window_log2, 6) samples yields one request on result / result_valid /
//   result_stall, carrying the widened roughness and the fully_aligned flag.
//   window_log2 is written through cfg_valid / cfg_data (cfg_ready is always high) and
//   resets to 1. Write it only while the block is idle; the block does not check this.
// Flow:
//   Each sample passes through the back end in turn: squaring, a square root and three
//   divisions, all on one shared multiplier, one square-root unit and one divider. The
//   window's last sample adds finishing steps (squared length, square root, variance
//   division where needed, final square root).
//   A two-entry queue lets the front end take up to two samples while the back end works.
//   The result sits in an output register; while result_stall is high it holds, and the
//   back end waits once it has the next result ready.
// Reset (arst_n low) clears the sums, the sample count and all valid flags.
`default_nettype none
module vmf_roughness_prefilter #(
	parameter int MAX_WINDOW_LOG2 = vrp_pkg::MAX_WINDOW_LOG2,
	parameter int SAMPLE_BITS = vrp_pkg::SAMPLE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  vrp_pkg::sample_t sample,
	output logic             result_valid,
	input  wire logic        result_stall,
	output vrp_pkg::result_t result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data
);

	logic            q_full;
	logic            push;
	vrp_pkg::qitem_t push_item;
	logic            pop;
	logic            avail;
	vrp_pkg::qitem_t head;

	vrp_front #(
		.MAX_WINDOW_LOG2(MAX_WINDOW_LOG2)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.q_full(q_full),
		.push(push),
		.push_item(push_item)
	);

	vrp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.avail(avail),
		.head(head)
	);

	vrp_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.avail(avail),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule
`default_nettype wire

FILE: src/vrp_queue.sv
// Two-entry queue between the sample front end and the arithmetic back end.
`default_nettype none
module vrp_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  vrp_pkg::qitem_t      push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 avail,
	output vrp_pkg::qitem_t      head
);

	vrp_pkg::qitem_t mem_q [vrp_pkg::QUEUE_DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;

	assign full = (count_q == 2'(vrp_pkg::QUEUE_DEPTH));
	assign avail = (count_q != 2'd0);
	assign head = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

FILE: src/vrp_front.sv
// Front end: holds the window size, counts samples and marks each window's last one.
`default_nettype none
module vrp_front #(
	parameter int MAX_WINDOW_LOG2 = vrp_pkg::MAX_WINDOW_LOG2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sample_valid,
	output logic             sample_stall,
	input  vrp_pkg::sample_t sample,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,
	input  wire logic        q_full,
	output logic             push,
	output vrp_pkg::qitem_t  push_item
);

	localparam int CW = 2 * MAX_WINDOW_LOG2 + 1;

	logic [2:0]                  window_log2_q;
	logic [CW-1:0]               seen_q;
	logic [CW-1:0]               seen_nx;
	logic [vrp_pkg::WLOG_W-1:0]  w_eff;
	logic                        last;

	assign cfg_ready = 1'b1;
	assign sample_stall = q_full;
	assign push = sample_valid && !q_full;

	always_comb begin
		if ({1'b0, window_log2_q} > vrp_pkg::WLOG_W'(MAX_WINDOW_LOG2))
			w_eff = vrp_pkg::WLOG_W'(MAX_WINDOW_LOG2);
		else
			w_eff = vrp_pkg::WLOG_W'(window_log2_q);
		seen_nx = seen_q + CW'(1);
		last = seen_nx >= (CW'(1) << (2 * w_eff));
		push_item.smp = sample;
		push_item.last = last;
		push_item.wlog = w_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_log2_q <= 3'd1;
			seen_q <= '0;
		end else begin
			if (cfg_valid) window_log2_q <= cfg_data;
			if (push) seen_q <= last ? '0 : seen_nx;
		end
	end

endmodule
`default_nettype wire

FILE: src/vrp_back.sv
// Back end: normalizes each sample, accumulates, and finishes a window with one shared
// multiplier, one iterative square root and one iterative divider.
`default_nettype none
module vrp_back #(
	parameter int SAMPLE_BITS = vrp_pkg::SAMPLE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        avail,
	input  vrp_pkg::qitem_t  head,
	output logic             pop,
	output logic             result_valid,
	input  wire logic        result_stall,
	output vrp_pkg::result_t result
);

	localparam int SB = SAMPLE_BITS;
	localparam int VW = SB + 2;
	localparam int NS = 29 - SB;
	localparam logic [VW-1:0] CODE_MAX = VW'((64'd1 << SB) - 64'd1);

	vrp_pkg::back_state_t state_q, state_nx;

	logic [VW-1:0]               v_q [3];
	logic [15:0]                 rough_q;
	logic                        last_q;
	logic [vrp_pkg::WLOG_W-1:0]  wlog_q;
	logic [1:0]                  idx_q;
	logic [63:0]                 acc_q;
	logic [31:0]                 len_q;
	logic [31:0]                 sum_q [3];
	logic [31:0]                 r30_q;
	logic [31:0]                 r2_q;
	logic [31:0]                 den_q;
	logic [31:0]                 wq_q;
	logic                        aligned_q;
	logic                        result_valid_q;
	vrp_pkg::result_t            result_q;

	logic [63:0] sq_x_q, sq_res_q, sq_bit_q;
	logic [63:0] sq_try, sq_x_nx, sq_res_nx;
	logic        sq_ge, sq_done;

	logic [63:0] dv_q;
	logic [31:0] rem_q, dsr_q;
	logic [5:0]  div_cnt_q;
	logic [32:0] rem_sh;
	logic        div_ge, div_done;
	logic [31:0] rem_nx;
	logic [63:0] dv_nx;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	logic [SB-1:0] cx [3];
	logic [VW-1:0] vin [3];
	logic [VW-1:0] vsel, vmag;
	logic [31:0]   ssel, sabs;
	logic [14:0]   qc;
	logic [31:0]   qs;
	logic [31:0]   num;
	logic [63:0]   numsh;
	logic          emit;
	logic [5:0]    sh_up, sh_dn;
	logic          big;

	// Decode of the incoming codes: v = 2c - M.
	always_comb begin
		cx[0] = SB'(head.smp.normal_x);
		cx[1] = SB'(head.smp.normal_y);
		cx[2] = SB'(head.smp.normal_z);
		for (int i = 0; i < 3; i++) vin[i] = {1'b0, cx[i], 1'b0} - CODE_MAX;
	end

	always_comb begin
		vsel = v_q[idx_q];
		vmag = vsel[VW-1] ? (~vsel + VW'(1)) : vsel;
		ssel = sum_q[idx_q];
		sabs = ssel[31] ? (~ssel + 32'd1) : ssel;
	end

	// Square root step: one result bit at a time.
	always_comb begin
		sq_try = sq_res_q + sq_bit_q;
		sq_ge = sq_x_q >= sq_try;
		sq_x_nx = sq_ge ? (sq_x_q - sq_try) : sq_x_q;
		sq_res_nx = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);
		sq_done = sq_bit_q[0];
	end

	// Restoring divider step: one quotient bit per cycle.
	always_comb begin
		rem_sh = {rem_q, dv_q[63]};
		div_ge = rem_sh >= {1'b0, dsr_q};
		rem_nx = div_ge ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
		dv_nx = {dv_q[62:0], div_ge};
		div_done = (div_cnt_q == 6'd63);
	end

	always_comb begin
		case (state_q)
			vrp_pkg::BS_SQ: begin
				mul_a = 32'(vmag);
				mul_b = 32'(vmag);
			end
			vrp_pkg::BS_SUMSQ: begin
				mul_a = sabs;
				mul_b = sabs;
			end
			vrp_pkg::BS_R2: begin
				mul_a = r30_q;
				mul_b = r30_q;
			end
			vrp_pkg::BS_DEN: begin
				mul_a = r30_q;
				mul_b = vrp_pkg::THREE_Q30 - r2_q;
			end
			vrp_pkg::BS_THR: begin
				mul_a = vrp_pkg::THRESH_Q32;
				mul_b = den_q;
			end
			vrp_pkg::BS_RMS: begin
				mul_a = 32'(rough_q);
				mul_b = 32'(rough_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);
	end

	always_comb begin
		if (|dv_nx[63:15]) qc = 15'h7FFF;
		else qc = dv_nx[14:0];
		if (len_q == 32'd0) qc = '0;
		qs = vsel[VW-1] ? (32'd0 - 32'(qc)) : 32'(qc);
		num = vrp_pkg::ONE_Q30 - r2_q;
		numsh = 64'(num) << 31;
		sh_up = 6'd30 - 6'(4 * wlog_q);
		sh_dn = 6'(4 * wlog_q) - 6'd30;
		big = (64'h4000_0000_0000_0000 >> sh_up) < acc_q;
		emit = (state_q == vrp_pkg::BS_EMIT) && (!result_valid_q || !result_stall);
	end

	always_comb begin
		state_nx = state_q;
		pop = 1'b0;
		case (state_q)
			vrp_pkg::BS_IDLE: begin
				if (avail) begin
					pop = 1'b1;
					state_nx = vrp_pkg::BS_SQ;
				end
			end
			vrp_pkg::BS_SQ: if (idx_q == 2'd2) state_nx = vrp_pkg::BS_NSQRT;
			vrp_pkg::BS_NSQRT: if (sq_done) state_nx = vrp_pkg::BS_DSET;
			vrp_pkg::BS_DSET: state_nx = vrp_pkg::BS_DIV;
			vrp_pkg::BS_DIV: begin
				if (div_done) begin
					if (idx_q != 2'd2) state_nx = vrp_pkg::BS_DSET;
					else if (last_q) state_nx = vrp_pkg::BS_SUMSQ;
					else state_nx = vrp_pkg::BS_IDLE;
				end
			end
			vrp_pkg::BS_SUMSQ: if (idx_q == 2'd2) state_nx = vrp_pkg::BS_RSET;
			vrp_pkg::BS_RSET: begin
				if (4 * wlog_q <= 30 && big) state_nx = vrp_pkg::BS_RMS;
				else state_nx = vrp_pkg::BS_RSQRT;
			end
			vrp_pkg::BS_RSQRT: begin
				if (sq_done) begin
					if (sq_res_nx >= 64'(vrp_pkg::ONE_Q30)) state_nx = vrp_pkg::BS_RMS;
					else state_nx = vrp_pkg::BS_R2;
				end
			end
			vrp_pkg::BS_R2: state_nx = vrp_pkg::BS_DEN;
			vrp_pkg::BS_DEN: state_nx = vrp_pkg::BS_THR;
			vrp_pkg::BS_THR: begin
				if (den_q == 32'd0 || numsh >= prod) state_nx = vrp_pkg::BS_RMS;
				else state_nx = vrp_pkg::BS_WDIV;
			end
			vrp_pkg::BS_WDIV: if (div_done) state_nx = vrp_pkg::BS_RMS;
			vrp_pkg::BS_RMS: state_nx = vrp_pkg::BS_OSQRT;
			vrp_pkg::BS_OSQRT: if (sq_done) state_nx = vrp_pkg::BS_EMIT;
			vrp_pkg::BS_EMIT: if (emit) state_nx = vrp_pkg::BS_IDLE;
			default: state_nx = vrp_pkg::BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrp_pkg::BS_IDLE;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end else begin
			state_q <= state_nx;
			if (emit) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
			if (state_q == vrp_pkg::BS_DIV && div_done) sum_q[idx_q] <= sum_q[idx_q] + qs;
			if (emit) for (int i = 0; i < 3; i++) sum_q[i] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			vrp_pkg::BS_IDLE: begin
				for (int i = 0; i < 3; i++) v_q[i] <= vin[i];
				rough_q <= head.smp.base_roughness;
				last_q <= head.last;
				wlog_q <= head.wlog;
				idx_q <= 2'd0;
				acc_q <= '0;
			end
			vrp_pkg::BS_SQ: begin
				acc_q <= acc_q + prod;
				idx_q <= idx_q + 2'd1;
				if (idx_q == 2'd2) begin
					idx_q <= 2'd0;
					sq_x_q <= (acc_q + prod) << (2 * NS);
					sq_res_q <= '0;
					sq_bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			vrp_pkg::BS_NSQRT: begin
				sq_x_q <= sq_x_nx;
				sq_res_q <= sq_res_nx;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_done) len_q <= sq_res_nx[31:0];
			end
			vrp_pkg::BS_DSET: begin
				dv_q <= (64'(vmag) << (NS + 15)) + 64'(len_q >> 1);
				dsr_q <= len_q;
				rem_q <= '0;
				div_cnt_q <= '0;
			end
			vrp_pkg::BS_DIV: begin
				dv_q <= dv_nx;
				rem_q <= rem_nx;
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_done) begin
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd2) begin
						idx_q <= 2'd0;
						acc_q <= '0;
					end
				end
			end
			vrp_pkg::BS_SUMSQ: begin
				acc_q <= acc_q + prod;
				idx_q <= idx_q + 2'd1;
			end
			vrp_pkg::BS_RSET: begin
				sq_res_q <= '0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
				if (4 * wlog_q <= 30) sq_x_q <= acc_q << sh_up;
				else sq_x_q <= acc_q >> sh_dn;
				// Too large to shift up: the average is clamped to unit length.
				if (4 * wlog_q <= 30 && big) begin
					r30_q <= vrp_pkg::ONE_Q30;
					aligned_q <= 1'b1;
					wq_q <= '0;
				end
			end
			vrp_pkg::BS_RSQRT: begin
				sq_x_q <= sq_x_nx;
				sq_res_q <= sq_res_nx;
				sq_bit_q <= sq_bit_q >> 2;
				if (sq_done) begin
					r30_q <= sq_res_nx[31:0];
					aligned_q <= sq_res_nx >= 64'(vrp_pkg::ONE_Q30);
					wq_q <= '0;
				end
			end
			vrp_pkg::BS_R2: r2_q <= prod[61:30];
			vrp_pkg::BS_DEN: den_q <= prod[61:30];
			vrp_pkg::BS_THR: begin
				wq_q <= vrp_pkg::THRESH_Q32;
				dv_q <= numsh;
				dsr_q <= den_q;
				rem_q <= '0;
				div_cnt_q <= '0;
			end
			vrp_pkg::BS_WDIV: begin
				dv_q <= dv_nx;
				rem_q <= rem_nx;
				div_cnt_q <= div_cnt_q + 6'd1;
				if (div_done) wq_q <= dv_nx[31:0];
			end
			vrp_pkg::BS_RMS: begin
				sq_x_q <= prod + 64'(wq_q);
				sq_res_q <= '0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
			end
			vrp_pkg::BS_OSQRT: begin
				sq_x_q <= sq_x_nx;
				sq_res_q <= sq_res_nx;
				sq_bit_q <= sq_bit_q >> 2;
			end
			vrp_pkg::BS_EMIT: begin
				if (emit) begin
					result_q.roughness_out <= (|sq_res_q[63:16]) ? 16'hFFFF : sq_res_q[15:0];
					result_q.fully_aligned <= aligned_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the vMF roughness prefilter.
`default_nettype none
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	vrp_pkg::sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	vrp_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_data = 3'd0;

	always #2 clk = ~clk;

	vmf_roughness_prefilter dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Own copy of the filter state.
	logic [31:0] acc_x, acc_y, acc_z;
	int unsigned taps_seen;
	logic [2:0] win_log2;

	vrp_pkg::result_t rough_q[$];
	int errors = 0;
	int n_texels = 0;
	int n_windows = 0;
	int n_aligned = 0;
	bit calm = 1'b0;

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] unit_q15(input longint v, input logic [63:0] len);
		logic [63:0] mag, q;
		mag = v < 0 ? -v : v;
		if (len == 0)
			return 32'd0;
		q = ((mag << 28) + (len >> 1)) / len;
		if (q > 32767)
			q = 32767;
		return v < 0 ? -q[31:0] : q[31:0];
	endfunction

	function automatic logic [63:0] sq_mag(input logic [31:0] s);
		logic [63:0] m;
		m = {32'd0, s[31] ? -s : s};
		return m * m;
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[64] ? 64'hFFFF_FFFF_FFFF_FFFF : t[63:0];
	endfunction

	// Folds one texel into the window; returns 1 with the result when the window closes.
	function automatic bit fold_texel(input vrp_pkg::sample_t s, output vrp_pkg::result_t r);
		longint vx, vy, vz;
		logic [63:0] len, sq, r30, r2, num, den, wq, q;
		int w, e;
		bit aligned;
		vx = 2 * longint'(s.normal_x) - 65535;
		vy = 2 * longint'(s.normal_y) - 65535;
		vz = 2 * longint'(s.normal_z) - 65535;
		len = isqrt((vx * vx + vy * vy + vz * vz) << 26);
		acc_x += unit_q15(vx, len);
		acc_y += unit_q15(vy, len);
		acc_z += unit_q15(vz, len);
		taps_seen++;
		w = win_log2 > vrp_pkg::MAX_WINDOW_LOG2 ? vrp_pkg::MAX_WINDOW_LOG2 : win_log2;
		r = '0;
		if (taps_seen < (1 << (2 * w)))
			return 1'b0;
		sq = add_sat(add_sat(sq_mag(acc_x), sq_mag(acc_y)), sq_mag(acc_z));
		e = 30 - 4 * w;
		if (e >= 0)
			r30 = (sq > ((64'd1 << 62) >> e)) ? (64'd1 << 30) : isqrt(sq << e);
		else
			r30 = isqrt(sq >> (-e));
		aligned = r30 >= (64'd1 << 30);
		if (aligned) begin
			wq = 0;
		end else begin
			r2 = (r30 * r30) >> 30;
			num = (64'd1 << 30) - r2;
			den = (r30 * ((64'd3 << 30) - r2)) >> 30;
			if (den == 0 || (num << 31) >= 64'(vrp_pkg::THRESH_Q32) * den)
				wq = 64'(vrp_pkg::THRESH_Q32);
			else
				wq = (num << 31) / den;
		end
		q = isqrt(64'(s.base_roughness) * 64'(s.base_roughness) + wq);
		r.roughness_out = q > 65535 ? 16'hFFFF : q[15:0];
		r.fully_aligned = aligned;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		taps_seen = 0;
		return 1'b1;
	endfunction

	// Result side: random stall per request, checked against the oldest expectation.
	int n_taken = 0;
	int n_drawn = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (n_drawn != n_taken) begin
			n_drawn = n_taken;
			stall_left = calm ? 0 : $urandom_range(0, 14);
		end
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (rough_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h/%b", result.roughness_out,
						result.fully_aligned);
			end else begin
				if (result !== rough_q[0]) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected %h/%b got %h/%b",
							rough_q[0].roughness_out, rough_q[0].fully_aligned,
							result.roughness_out, result.fully_aligned);
				end
				if (rough_q[0].fully_aligned)
					n_aligned++;
				void'(rough_q.pop_front());
				n_windows++;
			end
			n_taken++;
		end
	end

	task automatic push_texel(input vrp_pkg::sample_t s, input bit typed,
		input vrp_pkg::result_t typed_r);
		vrp_pkg::result_t r;
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_stall);
		n_texels++;
		if (fold_texel(s, r))
			rough_q.push_back(typed ? typed_r : r);
		if (!calm)
			repeat ($urandom_range(0, 14)) begin
				@(negedge clk);
				sample_valid <= 1'b0;
			end
	endtask

	// Writes window_log2 once the block has drained and finished any partial work.
	task automatic set_window(input logic [2:0] v);
		@(negedge clk);
		sample_valid <= 1'b0;
		while (rough_q.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		win_log2 = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic vrp_pkg::sample_t make_texel(input int style,
		input vrp_pkg::sample_t dir);
		vrp_pkg::sample_t s;
		s = {$urandom, $urandom};
		case (style)
			1: begin
				s.normal_x = dir.normal_x ^ 16'($urandom_range(0, 255));
				s.normal_y = dir.normal_y ^ 16'($urandom_range(0, 255));
				s.normal_z = dir.normal_z ^ 16'($urandom_range(0, 255));
			end
			2: begin
				s.normal_x = dir.normal_x;
				s.normal_y = dir.normal_y;
				s.normal_z = dir.normal_z;
			end
			default: ;
		endcase
		return s;
	endfunction

	typedef struct {
		bit is_cfg;
		logic [2:0] wl;
		vrp_pkg::sample_t s;
		bit typed;
		vrp_pkg::result_t r;
	} step_t;

	// Opening rows: the first four cancel exactly, giving a zero average.
	step_t steps[] = '{
		'{0, 0, '{16'hFFFF, 16'h8000, 16'h8000, 16'h0000}, 0, '0},
		'{0, 0, '{16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000}, 0, '0},
		'{0, 0, '{16'h8000, 16'hFFFF, 16'h8000, 16'h0000}, 0, '0},
		'{0, 0, '{16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000}, 1, '{16'd13107, 1'b0}},
		'{0, 0, '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF}, 0, '0},
		'{0, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 0, '0},
		'{0, 0, '{16'h1234, 16'hFEDC, 16'h8001, 16'h8000}, 0, '0},
		'{0, 0, '{16'h0001, 16'h7FFE, 16'hAAAA, 16'hFFFF}, 0, '0},
		'{1, 0, '0, 0, '0},
		'{0, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{16'hFFFF, 1'b1}},
		'{0, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1, '{16'h0000, 1'b1}},
		'{0, 0, '{16'h0000, 16'h0000, 16'h0000, 16'h5555}, 0, '0},
		'{0, 0, '{16'hFFFF, 16'h8000, 16'h8000, 16'h0001}, 0, '0},
		'{0, 0, '{16'h5555, 16'h0000, 16'hFFFF, 16'hFFFE}, 0, '0},
		'{1, 7, '0, 0, '0},
		'{0, 0, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000}, 0, '0},
		'{0, 0, '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 0, '0},
		'{0, 0, '{16'h8000, 16'h8000, 16'hFFFF, 16'h1000}, 0, '0},
		'{1, 0, '0, 0, '0},
		'{0, 0, '{16'h7FFF, 16'h7FFF, 16'h0000, 16'hC000}, 0, '0},
		'{1, 6, '0, 0, '0},
		'{0, 0, '{16'h4000, 16'hC000, 16'h2000, 16'h2000}, 0, '0},
		'{1, 2, '0, 0, '0},
		'{0, 0, '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0100}, 0, '0}
	};

	initial begin
		int wl, nwin, style, len, size;
		vrp_pkg::sample_t dir;
		acc_x = 0;
		acc_y = 0;
		acc_z = 0;
		taps_seen = 0;
		win_log2 = 3'd1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (steps[i]) begin
			if (steps[i].is_cfg)
				set_window(steps[i].wl);
			else
				push_texel(steps[i].s, steps[i].typed, steps[i].r);
		end

		// One full 64-texel window, then random phases of mostly small windows.
		set_window(3'd3);
		dir = {$urandom, $urandom};
		repeat (64) push_texel(make_texel(1, dir), 0, '0);

		while (n_texels < 750) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin wl = 0; nwin = $urandom_range(10, 40); end
				4, 5, 6: begin wl = 1; nwin = $urandom_range(3, 10); end
				7, 8: begin wl = 2; nwin = $urandom_range(1, 3); end
				default: begin wl = $urandom_range(3, 7); nwin = 0; end
			endcase
			set_window(3'(wl));
			calm = ($urandom_range(0, 3) == 0);
			size = (wl > vrp_pkg::MAX_WINDOW_LOG2) ? 4096 : (1 << (2 * wl));
			// A broken window: a few texels, closed later under another setting.
			len = nwin == 0 ? $urandom_range(1, 20) : nwin * size;
			style = $urandom_range(0, 2);
			dir = {$urandom, $urandom};
			for (int k = 0; k < len; k++) begin
				if (k % size == 0 && $urandom_range(0, 1))
					dir = {$urandom, $urandom};
				push_texel(make_texel(style, dir), 0, '0);
			end
		end
		calm = 1'b0;
		set_window(3'd0);
		push_texel({$urandom, $urandom}, 0, '0);

		@(negedge clk);
		sample_valid <= 1'b0;
		while (rough_q.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		$display("Sent %0d texels, checked %0d windows (%0d fully aligned).",
			n_texels, n_windows, n_aligned);
		$display("Window sizes 0..7 with mid-window changes; %0d errors.", errors);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
